// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps

package stl_pkg;

  typedef enum logic [1:0] {
    ACT_TILE   = 2'd0,
    ACT_MAP    = 2'd1,
    ACT_COLOUR = 2'd2,
    ACT_RENDER = 2'd3
  } action_t;

  localparam logic [1:0] CFG_SCROLL_X = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y = 2'd1;
  localparam logic [1:0] CFG_ENABLE   = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  LINE_OFFSET   = 8'd16;
  localparam logic [19:0] COLOUR_DEPTH  = 20'd512;

  typedef struct packed {
    action_t     action;
    logic [18:0] address;
    logic [7:0]  load_data;
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
  } in_t;

  typedef struct packed {
    logic [5:0] pen;
    logic [7:0] frame_col;
    logic [7:0] frame_row;
  } out_t;

  // fields carried down the pixel pipeline
  typedef struct packed {
    action_t     action;
    logic [18:0] addr;
    logic [7:0]  data;
    logic [7:0]  frame_col;
    logic [7:0]  frame_row;
    logic        en;
    logic [2:0]  row;
    logic [4:0]  iy;
    logic [4:0]  sub;
    logic [4:0]  fy;
    logic [4:0]  fx;
    logic [3:0]  group;
  } stage_t;

endpackage

// ===== design/stl_ram.sv =====
`timescale 1ns / 1ps

module stl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stl_cmod.sv =====
`timescale 1ns / 1ps

// remainder by a constant: reciprocal estimate, back-multiply, one correction
module stl_cmod #(
  parameter int VW  = 11,
  parameter int DIV = 8,
  parameter int OW  = 3
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] v,
  output logic [OW-1:0] r
);

  localparam int unsigned RCP = (2 ** VW) / DIV;
  localparam int RW = $clog2(RCP + 2);
  localparam int DW = $clog2(DIV + 1);
  localparam int PW = VW + RW;
  localparam int MW = VW + DW;

  logic [PW-1:0] prod;
  logic [VW-1:0] q_nxt;
  logic [VW-1:0] v1_r, q1_r;
  logic [MW-1:0] qm_full;
  logic [VW-1:0] qm_nxt;
  logic [VW-1:0] v2_r, qm2_r;
  logic [VW-1:0] rem, rem_fix;

  // estimate is the true quotient or one below it
  assign prod  = PW'(v) * PW'(RCP);
  assign q_nxt = VW'(prod >> VW);

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= v;
      q1_r <= q_nxt;
    end
  end

  assign qm_full = MW'(q1_r) * MW'(DIV);
  assign qm_nxt  = VW'(qm_full);

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r  <= v1_r;
      qm2_r <= qm_nxt;
    end
  end

  always_comb begin
    rem     = v2_r - qm2_r;
    rem_fix = (MW'(rem) >= MW'(DIV)) ? rem - VW'(DIV) : rem;
  end

  assign r = OW'(rem_fix);

endmodule

// ===== design/stl_obuf.sv =====
`timescale 1ns / 1ps

module stl_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stl_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output stl_pkg::out_t out_data
);

  stl_pkg::out_t ent_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wr_ptr_r, rd_ptr_r;
  logic          pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = ent_r[rd_ptr_r];
  assign cnt_nxt   = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/scrolling_tilemap_layer_pixel_unit.sv =====
`timescale 1ns / 1ps

// Scrolling tile background, one pixel per render transfer.
// in_data carries an action: three load actions write the tile pixel store,
// the map byte store or a colour table entry and give no result; a render
// action gives one result on out_data (pen, frame_col, frame_row).
// Both channels move a transfer when valid is high and stall is low.
// cfg_ready is always high; the user must write scroll_x, scroll_y and
// layer_enable only between frames while no item is in flight; the block
// itself does not enforce this. Throughput: one item per cycle while
// in_stall is low. The map read, the tile read and the colour read each
// take one stage, with a constant-remainder unit (two stages) in front of
// the map and tile reads.
// Reset clears the pipeline valid bits and the output buffer, sets scroll to
// 0 and enables the layer. The stores are not cleared and must be loaded
// before they are rendered from.
// A 2-entry output buffer absorbs receiver stalls; in_stall rises and the
// whole pipeline freezes only once both entries are full.

module scrolling_tilemap_layer_pixel_unit #(
  parameter int TILE_COUNT  = 512,
  parameter int MAP_COLUMNS = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  stl_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output stl_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [stl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int TILE_DEPTH = TILE_COUNT * 1024;
  localparam int TA_W       = $clog2(TILE_DEPTH);
  localparam int TILE_W     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int MAP_DEPTH  = MAP_COLUMNS * 16;
  localparam int MH_DEPTH   = MAP_COLUMNS * 8;
  localparam int MH_W       = $clog2(MH_DEPTH);
  localparam int COL_W      = $clog2(MAP_COLUMNS);

  // configuration
  logic [15:0] scroll_x_r;
  logic [7:0]  scroll_y_r;
  logic        layer_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= 16'd0;
      scroll_y_r <= 8'd0;
      layer_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stl_pkg::CFG_SCROLL_X: scroll_x_r <= cfg_data;
        stl_pkg::CFG_SCROLL_Y: scroll_y_r <= cfg_data[7:0];
        stl_pkg::CFG_ENABLE:   layer_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move together
  logic adv;
  logic ob_full;
  logic ob_push;
  stl_pkg::out_t ob_data;

  assign adv      = !ob_full;
  assign in_stall = ob_full;

  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r, g_vld_r, h_vld_r;
  stl_pkg::stage_t a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  stl_pkg::stage_t a_nxt, e_nxt;
  logic [10:0] a_colv_r;
  logic [15:0] wx;
  logic [7:0]  wy;

  always_comb begin
    wx = 16'({8'd0, in_data.screen_x} + scroll_x_r);
    wy = 8'(in_data.screen_y + stl_pkg::LINE_OFFSET + scroll_y_r);
    a_nxt           = '0;
    a_nxt.action    = in_data.action;
    a_nxt.addr      = in_data.address;
    a_nxt.data      = in_data.load_data;
    a_nxt.frame_col = in_data.screen_y;
    a_nxt.frame_row = ~in_data.screen_x;
    a_nxt.en        = layer_en_r;
    a_nxt.row       = wy[7:5];
    a_nxt.iy        = wy[4:0];
    a_nxt.sub       = wx[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r      <= a_nxt;
      a_colv_r <= wx[15:5];
      b_r      <= a_r;
      c_r      <= b_r;
      d_r      <= c_r;
      e_r      <= e_nxt;
      f_r      <= e_r;
      g_r      <= f_r;
      h_r      <= g_r;
    end
  end

  // map column wraps at the map width
  logic [COL_W-1:0] col;

  stl_cmod #(
    .VW  (11),
    .DIV (MAP_COLUMNS),
    .OW  (COL_W)
  ) u_col_mod (
    .clk (clk),
    .en  (adv),
    .v   (a_colv_r),
    .r   (col)
  );

  // map fetch: code bytes at even, attribute bytes at odd addresses
  logic            map_load;
  logic [MH_W-1:0] map_addr;
  logic [7:0]      code_byte, attr_byte;

  assign map_load = c_vld_r && (c_r.action == stl_pkg::ACT_MAP) &&
                    ({1'b0, c_r.addr} < 20'(MAP_DEPTH));
  assign map_addr = map_load ? MH_W'(c_r.addr[18:1]) : {col, c_r.row};

  stl_ram #(.W(8), .DEPTH(MH_DEPTH)) u_map_code (
    .clk   (clk),
    .en    (adv),
    .we    (map_load && !c_r.addr[0]),
    .addr  (map_addr),
    .wdata (c_r.data),
    .rdata (code_byte)
  );

  stl_ram #(.W(8), .DEPTH(MH_DEPTH)) u_map_attr (
    .clk   (clk),
    .en    (adv),
    .we    (map_load && c_r.addr[0]),
    .addr  (map_addr),
    .wdata (c_r.data),
    .rdata (attr_byte)
  );

  // flips and colour group from the attribute
  logic [8:0] code;

  always_comb begin
    code        = {attr_byte[0], code_byte};
    e_nxt       = d_r;
    e_nxt.fy    = attr_byte[7] ? ~d_r.iy : d_r.iy;
    e_nxt.fx    = attr_byte[6] ? ~d_r.sub : d_r.sub;
    e_nxt.group = attr_byte[5:2];
  end

  logic [TILE_W-1:0] tile;

  stl_cmod #(
    .VW  (9),
    .DIV (TILE_COUNT),
    .OW  (TILE_W)
  ) u_tile_mod (
    .clk (clk),
    .en  (adv),
    .v   (code),
    .r   (tile)
  );

  // tile pixel fetch
  logic            tile_load;
  logic [TA_W-1:0] tile_addr;
  logic [3:0]      pix;

  assign tile_load = f_vld_r && (f_r.action == stl_pkg::ACT_TILE) &&
                     ({2'b0, f_r.addr} < 21'(TILE_DEPTH));
  assign tile_addr = tile_load ? TA_W'(f_r.addr) : TA_W'({tile, f_r.fy, f_r.fx});

  stl_ram #(.W(4), .DEPTH(TILE_DEPTH)) u_tile (
    .clk   (clk),
    .en    (adv),
    .we    (tile_load),
    .addr  (tile_addr),
    .wdata (f_r.data[3:0]),
    .rdata (pix)
  );

  // colour lookup
  logic       col_load;
  logic [7:0] colour_addr;
  logic [3:0] pen_lo;
  logic [1:0] pen_hi;

  assign col_load    = g_vld_r && (g_r.action == stl_pkg::ACT_COLOUR) &&
                       ({1'b0, g_r.addr} < stl_pkg::COLOUR_DEPTH);
  assign colour_addr = col_load ? g_r.addr[7:0] : {g_r.group, pix};

  stl_ram #(.W(4), .DEPTH(256)) u_colour_lo (
    .clk   (clk),
    .en    (adv),
    .we    (col_load && !g_r.addr[8]),
    .addr  (colour_addr),
    .wdata (g_r.data[3:0]),
    .rdata (pen_lo)
  );

  stl_ram #(.W(2), .DEPTH(256)) u_colour_hi (
    .clk   (clk),
    .en    (adv),
    .we    (col_load && g_r.addr[8]),
    .addr  (colour_addr),
    .wdata (g_r.data[1:0]),
    .rdata (pen_hi)
  );

  // result into the output buffer
  always_comb begin
    ob_push           = adv && h_vld_r && (h_r.action == stl_pkg::ACT_RENDER);
    ob_data.pen       = h_r.en ? {pen_hi, pen_lo} : 6'd0;
    ob_data.frame_col = h_r.frame_col;
    ob_data.frame_row = h_r.frame_row;
  end

  stl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ob_push),
    .push_data (ob_data),
    .full      (ob_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_freeze_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && h_vld_r) |=> (h_vld_r && $stable(h_r.frame_row) && $stable(h_r.action)))
    else $error("last stage changed while pipeline frozen");

  a_render_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && h_vld_r && (h_r.action == stl_pkg::ACT_RENDER)) |=> out_valid)
    else $error("render left the pipeline without a result");
`endif

endmodule
